// ===== src/p2sm_pkg.sv =====
`default_nettype none
package p2sm_pkg;

   localparam int TIMEOUT_W   = 20;
   localparam int BYTE_W      = 8;
   localparam int FRAME_W     = 9;
   localparam int CSR_INDEX_W = 2;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);
   localparam int PKT_RESULTS = 5;
   localparam int IDX_W       = $clog2(PKT_RESULTS);

   localparam logic [TIMEOUT_W-1:0] IDLE_TIMEOUT_RST  = TIMEOUT_W'(1000000);
   localparam logic [TIMEOUT_W-1:0] RETRY_TIMEOUT_RST = TIMEOUT_W'(200000);
   localparam logic [BYTE_W-1:0]    SAMPLE_RATE_RST   = BYTE_W'(20);

   localparam logic [BYTE_W-1:0]  SELF_TEST_PASS = 8'hAA;
   localparam logic [BYTE_W-1:0]  MOUSE_ACK      = 8'hFA;
   localparam logic [FRAME_W-1:0] FRAME_SET_RATE = 9'h1F3;
   localparam logic [FRAME_W-1:0] FRAME_ENABLE   = 9'h0F4;
   localparam logic [FRAME_W-1:0] FRAME_RESET    = 9'h1FF;
   localparam logic [BYTE_W-1:0]  AXIS_MAX       = 8'h7F;
   localparam logic [BYTE_W-1:0]  AXIS_MIN       = 8'h80;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IDLE_TIMEOUT  = 2'd0,
      CSR_RETRY_TIMEOUT = 2'd1,
      CSR_SAMPLE_RATE   = 2'd2
   } csr_index_type;

   typedef enum logic [0:0] {
      REQ_RX_BYTE = 1'b0,
      REQ_TICK    = 1'b1
   } req_cmd_type;

   typedef enum logic [0:0] {
      DEST_MOUSE = 1'b0,
      DEST_HOST  = 1'b1
   } dest_type;

   typedef enum logic [3:0] {
      PH_SELF_TEST = 4'd0,
      PH_ERROR     = 4'd1,
      PH_MOUSE_ID  = 4'd2,
      PH_ACK_SET   = 4'd3,
      PH_ACK_RATE  = 4'd4,
      PH_ACK_EN    = 4'd5,
      PH_BYTE1     = 4'd6,
      PH_BYTE2     = 4'd7,
      PH_BYTE3     = 4'd8
   } phase_type;

   typedef enum logic [0:0] {
      JOB_FRAME  = 1'b0,
      JOB_PACKET = 1'b1
   } job_kind_type;

   typedef struct packed {
      job_kind_type         kind;
      logic [FRAME_W-1:0]   frame;
      logic [BYTE_W-1:0]    btn;
      logic [BYTE_W-1:0]    dx;
      logic [BYTE_W-1:0]    dy;
      logic                 in_error;
   } job_type;

   function automatic logic [FRAME_W-1:0] odd_frame(input logic [BYTE_W-1:0] b);
      odd_frame = {~(^b), b};
   endfunction

   function automatic logic [BYTE_W-1:0] sat_axis(input logic ovf, input logic neg,
                                                  input logic [BYTE_W-1:0] mag);
      if (ovf) begin
         sat_axis = neg ? AXIS_MIN : AXIS_MAX;
      end else if (neg) begin
         sat_axis = mag[BYTE_W-1] ? mag : AXIS_MIN;
      end else begin
         sat_axis = mag[BYTE_W-1] ? AXIS_MAX : mag;
      end
   endfunction

endpackage
`default_nettype wire

// ===== src/p2sm_front.sv =====
`default_nettype none
module p2sm_front (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   input  wire logic                            req_cmd,
   input  wire logic [p2sm_pkg::BYTE_W-1:0]     req_rx_byte,
   input  wire logic                            queue_full,
   output logic                                 req_stall,
   output logic                                 push,
   output p2sm_pkg::job_type                    push_job,
   input  wire logic                            csr_wr_en,
   input  wire logic [p2sm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [p2sm_pkg::TIMEOUT_W-1:0]  csr_wdata
);
   import p2sm_pkg::*;

   logic [TIMEOUT_W-1:0] idle_timeout_ff, idle_timeout_in;
   logic [TIMEOUT_W-1:0] retry_timeout_ff, retry_timeout_in;
   logic [BYTE_W-1:0]    sample_rate_ff, sample_rate_in;
   phase_type            phase_ff, phase_in;
   logic [BYTE_W-1:0]    packet_first_ff, packet_first_in;
   logic [BYTE_W-1:0]    packet_second_ff, packet_second_in;
   logic [TIMEOUT_W-1:0] timeout_ff, timeout_in;
   logic                 accept;
   logic                 is_tick;
   logic                 is_ack;

   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;
   assign is_tick   = (req_cmd == REQ_TICK);
   assign is_ack    = (req_rx_byte == MOUSE_ACK);

   always_comb begin
      idle_timeout_in  = idle_timeout_ff;
      retry_timeout_in = retry_timeout_ff;
      sample_rate_in   = sample_rate_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_IDLE_TIMEOUT:  idle_timeout_in  = csr_wdata;
            CSR_RETRY_TIMEOUT: retry_timeout_in = csr_wdata;
            CSR_SAMPLE_RATE:   sample_rate_in   = csr_wdata[BYTE_W-1:0];
            default: ;
         endcase
      end
   end

   // next state
   always_comb begin
      phase_in         = phase_ff;
      timeout_in       = timeout_ff;
      packet_first_in  = packet_first_ff;
      packet_second_in = packet_second_ff;
      if (accept) begin
         if (is_tick) begin
            if (timeout_ff == '0) begin
               timeout_in = retry_timeout_ff;
               phase_in   = PH_SELF_TEST;
            end else begin
               timeout_in = timeout_ff - TIMEOUT_W'(1);
            end
         end else begin
            timeout_in = idle_timeout_ff;
            unique case (phase_ff)
               PH_MOUSE_ID: phase_in = PH_ACK_SET;
               PH_ACK_SET:  phase_in = is_ack ? PH_ACK_RATE : PH_ERROR;
               PH_ACK_RATE: phase_in = is_ack ? PH_ACK_EN : PH_ERROR;
               PH_ACK_EN:   phase_in = is_ack ? PH_BYTE1 : PH_ERROR;
               PH_BYTE1: begin
                  packet_first_in = req_rx_byte;
                  phase_in        = PH_BYTE2;
               end
               PH_BYTE2: begin
                  packet_second_in = req_rx_byte;
                  phase_in         = PH_BYTE3;
               end
               PH_BYTE3:    phase_in = PH_BYTE1;
               default:     phase_in = (req_rx_byte == SELF_TEST_PASS) ? PH_MOUSE_ID : PH_ERROR;
            endcase
         end
      end
   end

   // outputs
   always_comb begin
      push              = 1'b0;
      push_job.kind     = JOB_FRAME;
      push_job.frame    = FRAME_RESET;
      push_job.btn      = {1'b1, 4'b0000,
                           ~{packet_first_ff[0], packet_first_ff[2], packet_first_ff[1]}};
      push_job.dx       = sat_axis(packet_first_ff[6], packet_first_ff[4], packet_second_ff);
      push_job.dy       = sat_axis(packet_first_ff[7], packet_first_ff[5], req_rx_byte);
      push_job.in_error = (phase_in == PH_ERROR);
      if (accept) begin
         if (is_tick) begin
            push = (timeout_ff == '0);
         end else begin
            unique case (phase_ff)
               PH_MOUSE_ID: begin
                  push           = 1'b1;
                  push_job.frame = FRAME_SET_RATE;
               end
               PH_ACK_SET: begin
                  push           = is_ack;
                  push_job.frame = odd_frame(sample_rate_ff);
               end
               PH_ACK_RATE: begin
                  push           = is_ack;
                  push_job.frame = FRAME_ENABLE;
               end
               PH_BYTE3: begin
                  push          = 1'b1;
                  push_job.kind = JOB_PACKET;
               end
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idle_timeout_ff  <= IDLE_TIMEOUT_RST;
         retry_timeout_ff <= RETRY_TIMEOUT_RST;
         sample_rate_ff   <= SAMPLE_RATE_RST;
         phase_ff         <= PH_SELF_TEST;
         packet_first_ff  <= '0;
         packet_second_ff <= '0;
         timeout_ff       <= IDLE_TIMEOUT_RST;
      end else begin
         idle_timeout_ff  <= idle_timeout_in;
         retry_timeout_ff <= retry_timeout_in;
         sample_rate_ff   <= sample_rate_in;
         phase_ff         <= phase_in;
         packet_first_ff  <= packet_first_in;
         packet_second_ff <= packet_second_in;
         timeout_ff       <= timeout_in;
      end
   end

endmodule
`default_nettype wire

// ===== src/p2sm_queue.sv =====
`default_nettype none
module p2sm_queue (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire p2sm_pkg::job_type push_job,
   input  wire logic          pop,
   output p2sm_pkg::job_type  head_job,
   output logic               full,
   output logic               empty
);
   import p2sm_pkg::*;

   job_type               entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0]   count_ff, count_in;
   logic                  do_push;
   logic                  do_pop;

   assign full     = (count_ff == QUEUE_CW'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_job = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QUEUE_AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QUEUE_AW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QUEUE_CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QUEUE_CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

// ===== src/p2sm_back.sv =====
`default_nettype none
module p2sm_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          queue_empty,
   input  wire p2sm_pkg::job_type             head_job,
   output logic                               pop,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_dest,
   output logic [p2sm_pkg::FRAME_W-1:0]       rsp_value,
   output logic                               rsp_last,
   output logic                               rsp_in_error
);
   import p2sm_pkg::*;

   job_type             job_ff, job_in;
   logic                job_valid_ff, job_valid_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic                rsp_valid_ff, rsp_valid_in;
   dest_type            dest_ff, dest_in;
   logic [FRAME_W-1:0]  value_ff, value_in;
   logic                last_ff, last_in;
   logic                err_ff, err_in;
   logic                out_free;
   logic                emit;
   logic                item_last;
   logic                done;
   logic [BYTE_W-1:0]   pkt_byte;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign emit      = job_valid_ff && out_free;
   assign item_last = (job_ff.kind == JOB_FRAME) || (idx_ff == IDX_W'(PKT_RESULTS - 1));
   assign done      = emit && item_last;
   assign pop       = !queue_empty && (!job_valid_ff || done);

   always_comb begin
      unique case (idx_ff)
         IDX_W'(0): pkt_byte = job_ff.btn;
         IDX_W'(1): pkt_byte = job_ff.dx;
         IDX_W'(2): pkt_byte = job_ff.dy;
         default:   pkt_byte = '0;
      endcase
   end

   always_comb begin
      job_in       = pop ? head_job : job_ff;
      job_valid_in = pop ? 1'b1 : (done ? 1'b0 : job_valid_ff);
      idx_in       = (pop || done) ? '0 : (emit ? idx_ff + IDX_W'(1) : idx_ff);
      rsp_valid_in = emit ? 1'b1 : (out_free ? 1'b0 : rsp_valid_ff);
      dest_in      = dest_ff;
      value_in     = value_ff;
      last_in      = last_ff;
      err_in       = err_ff;
      if (emit) begin
         if (job_ff.kind == JOB_FRAME) begin
            dest_in  = DEST_MOUSE;
            value_in = job_ff.frame;
         end else begin
            dest_in  = DEST_HOST;
            value_in = {1'b0, pkt_byte};
         end
         last_in = item_last;
         err_in  = job_ff.in_error;
      end
   end

   always_ff @(posedge clock) begin
      job_ff   <= job_in;
      dest_ff  <= dest_in;
      value_ff <= value_in;
      last_ff  <= last_in;
      err_ff   <= err_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         job_valid_ff <= job_valid_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_dest     = dest_ff;
   assign rsp_value    = value_ff;
   assign rsp_last     = last_ff;
   assign rsp_in_error = err_ff;

endmodule
`default_nettype wire

// ===== src/ps2_mouse_to_serial_mouse_bridge.sv =====
`default_nettype none
// PS/2 mouse to five-byte serial mouse bridge. Each request transaction is a
// received mouse byte or one timeout tick. The front end accepts one request
// per cycle, runs bring-up (self-test pass, set-sample-rate, rate, enable,
// each acknowledgement checked), gathers three-byte packets and tracks the
// timeout; it hands work to the back end through a two-entry queue and stalls
// only while that queue is full. The back end sends one response transaction
// per cycle from its output register while rsp_stall is low: one for a frame
// to the mouse, five for a completed packet (buttons, dx, dy, 0, 0). Sustained
// throughput is therefore set by the single response port. Write csr registers
// only while the bridge is idle.
module ps2_mouse_to_serial_mouse_bridge (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic                             req_cmd,
   input  wire logic [p2sm_pkg::BYTE_W-1:0]      req_rx_byte,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic                                  rsp_dest,
   output logic [p2sm_pkg::FRAME_W-1:0]          rsp_value,
   output logic                                  rsp_last,
   output logic                                  rsp_in_error,
   input  wire logic                             csr_wr_en,
   input  wire logic [p2sm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [p2sm_pkg::TIMEOUT_W-1:0]   csr_wdata
);
   import p2sm_pkg::*;

   logic    push;
   job_type push_job;
   logic    pop;
   job_type head_job;
   logic    queue_full;
   logic    queue_empty;

   p2sm_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_cmd     (req_cmd),
      .req_rx_byte (req_rx_byte),
      .queue_full  (queue_full),
      .req_stall   (req_stall),
      .push        (push),
      .push_job    (push_job),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   p2sm_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .full     (queue_full),
      .empty    (queue_empty)
   );

   p2sm_back u_back (
      .clock        (clock),
      .reset        (reset),
      .queue_empty  (queue_empty),
      .head_job     (head_job),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_dest     (rsp_dest),
      .rsp_value    (rsp_value),
      .rsp_last     (rsp_last),
      .rsp_in_error (rsp_in_error)
   );

endmodule
`default_nettype wire
